FILE: rtl/lfu_replacement_table_defines.svh
// ----------------------------------------------------------------------------
// lfu replacement table assertion macros
// same-cycle and next-cycle implication property wrappers
// ----------------------------------------------------------------------------
`ifndef LFU_REPLACEMENT_TABLE_DEFINES_SVH
`define LFU_REPLACEMENT_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LFU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lfu table: same-cycle check failed");

// next-cycle implication
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lfu table: next-cycle check failed");

`else

`define LFU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/lfu_rt_pkg.sv
// ----------------------------------------------------------------------------
// lfu replacement table package
// widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lfu_rt_pkg;

	localparam int LFU_CAPACITY   = 16;
	localparam int LFU_COUNT_BITS = 16;

	localparam int KEY_W     = 32;
	localparam int STAMP_W   = 48;
	localparam int OUT_CNT_W = 16;
	localparam int STATUS_W  = 3;

	typedef enum logic {
		OP_ACCESS = 1'b0,
		OP_EVICT  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT    = 3'd0,
		ST_INSERT = 3'd1,
		ST_EVICT  = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic start;    // latch request, clear trackers, read entry 0
		logic rd_next;  // read the next entry
		logic commit;   // write back and load the response register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;  // last entry read has been issued
		logic out_free;   // response register can take a new response
	} dp_sts_t;

endpackage

FILE: rtl/lfu_rt_ram.sv
// ----------------------------------------------------------------------------
// lfu generic ram
// single write port, single read port with registered read data
// ----------------------------------------------------------------------------
module lfu_rt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/lfu_rt_ctrl.sv
// ----------------------------------------------------------------------------
// lfu table controller
// sequences request accept, entry scan and write-back
// ----------------------------------------------------------------------------
module lfu_rt_ctrl
	import lfu_rt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_last) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/lfu_rt_dp.sv
// ----------------------------------------------------------------------------
// lfu table datapath
// entry ram, valid bits, scan trackers, stamp counter, response register
// ----------------------------------------------------------------------------
module lfu_rt_dp
	import lfu_rt_pkg::*;
#(
	parameter int CAPACITY   = LFU_CAPACITY,
	parameter int COUNT_BITS = LFU_COUNT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             cmd,
	output dp_sts_t              sts,
	input  logic                 opcode,
	input  logic [KEY_W-1:0]     key,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [KEY_W-1:0]     key_out,
	output logic [OUT_CNT_W-1:0] count_out
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int REC_W = KEY_W + COUNT_BITS + STAMP_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

	// request
	op_t              op_q;
	logic [KEY_W-1:0] key_q;

	// scan address and read pipeline
	logic [IDX_W-1:0] addr_q;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	logic             rd_en_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [REC_W-1:0]      rec_rd;
	logic [KEY_W-1:0]      rd_key;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [STAMP_W-1:0]    rd_stamp;
	logic                  cur_valid;

	logic [CAPACITY-1:0] valid_q;
	logic [STAMP_W-1:0]  stamp_q;

	// trackers
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  best_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [STAMP_W-1:0]    best_stamp_q;
	logic [KEY_W-1:0]      best_key_q;

	logic take_hit;
	logic take_free;
	logic take_best;

	// write-back
	logic                  sat;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [COUNT_BITS-1:0] wcnt;
	logic [REC_W-1:0]      wdata;
	logic                  set_valid;
	logic                  clr_valid;

	// response
	logic                  rsp_valid_q;
	status_t               status_q;
	logic [KEY_W-1:0]      key_out_q;
	logic [OUT_CNT_W-1:0]  count_out_q;
	status_t               res_status;
	logic [KEY_W-1:0]      res_key;
	logic [COUNT_BITS-1:0] res_cnt;
	logic [31:0]           res_cnt_ext;

	assign rd_en   = cmd.start | cmd.rd_next;
	assign rd_addr = cmd.start ? '0 : addr_q + IDX_W'(1);

	lfu_rt_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rec_rd)
	);

	assign rd_key    = rec_rd[REC_W-1 -: KEY_W];
	assign rd_cnt    = rec_rd[STAMP_W +: COUNT_BITS];
	assign rd_stamp  = rec_rd[STAMP_W-1:0];
	assign cur_valid = valid_q[idx_s1];

	assign take_hit  = rd_en_s1 & cur_valid & ~hit_q & (rd_key == key_q);
	assign take_free = rd_en_s1 & ~cur_valid & ~free_q;
	assign take_best = rd_en_s1 & cur_valid &
		(~best_q | (rd_cnt < best_cnt_q) |
		 ((rd_cnt == best_cnt_q) & (rd_stamp > best_stamp_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1 <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			best_q   <= 1'b0;
		end else begin
			rd_en_s1 <= rd_en;
			if (cmd.start) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				best_q <= 1'b0;
			end else begin
				if (take_hit) begin
					hit_q <= 1'b1;
				end
				if (take_free) begin
					free_q <= 1'b1;
				end
				if (take_best) begin
					best_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= op_t'(opcode);
			key_q <= key;
		end
		if (rd_en) begin
			addr_q <= rd_addr;
			idx_s1 <= rd_addr;
		end
		if (take_hit) begin
			hit_idx_q <= idx_s1;
			hit_cnt_q <= rd_cnt;
		end
		if (take_free) begin
			free_idx_q <= idx_s1;
		end
		if (take_best) begin
			best_idx_q   <= idx_s1;
			best_cnt_q   <= rd_cnt;
			best_stamp_q <= rd_stamp;
			best_key_q   <= rd_key;
		end
	end

	assign sts.scan_last = (addr_q == IDX_LAST);
	assign sts.out_free  = ~rsp_valid_q | ~rsp_stall;

	// write-back of an unsaturated hit or an insert, valid clear of an evict
	assign sat       = (hit_cnt_q == CNT_MAX);
	assign we        = cmd.commit & (op_q == OP_ACCESS) & ((hit_q & ~sat) | (~hit_q & free_q));
	assign waddr     = hit_q ? hit_idx_q : free_idx_q;
	assign wcnt      = hit_q ? hit_cnt_q + COUNT_BITS'(1) : COUNT_BITS'(1);
	assign wdata     = {key_q, wcnt, stamp_q};
	assign set_valid = cmd.commit & (op_q == OP_ACCESS) & ~hit_q & free_q;
	assign clr_valid = cmd.commit & (op_q == OP_EVICT) & best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			stamp_q <= '0;
		end else begin
			if (we) begin
				stamp_q <= stamp_q + STAMP_W'(1);
			end
			if (set_valid) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	always_comb begin
		res_status = ST_EMPTY;
		res_key    = '0;
		res_cnt    = '0;
		if (op_q == OP_ACCESS) begin
			res_key = key_q;
			if (hit_q) begin
				res_status = ST_HIT;
				res_cnt    = sat ? hit_cnt_q : wcnt;
			end else if (free_q) begin
				res_status = ST_INSERT;
				res_cnt    = COUNT_BITS'(1);
			end else begin
				res_status = ST_FULL;
			end
		end else if (best_q) begin
			res_status = ST_EVICT;
			res_key    = best_key_q;
			res_cnt    = best_cnt_q;
		end
	end

	assign res_cnt_ext = 32'(res_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (~rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q    <= res_status;
			key_out_q   <= res_key;
			count_out_q <= res_cnt_ext[OUT_CNT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign key_out   = key_out_q;
	assign count_out = count_out_q;

endmodule

FILE: rtl/lfu_replacement_table.sv
// ----------------------------------------------------------------------------
// lfu replacement table
// keyed use-count table with least-frequently-used eviction
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   opcode, key
//  rsp       out        rsp_valid/rsp_stall   status, key_out, count_out
//
//  every request reads each entry once from the entry ram for the key match
//  and minimum-count search, waits for the last read data, then writes back
//  once the response register is free
//  reset clears the valid bits and the stamp counter at once; entry ram
//  contents need no clearing since entry data is only used while valid
//  a request is taken while a previous response still waits; write-back of
//  the new request holds until the response register is free
//
`include "lfu_replacement_table_defines.svh"

module lfu_replacement_table
	import lfu_rt_pkg::*;
#(
	parameter int CAPACITY   = LFU_CAPACITY,
	parameter int COUNT_BITS = LFU_COUNT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 opcode,
	input  logic [KEY_W-1:0]     key,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [KEY_W-1:0]     key_out,
	output logic [OUT_CNT_W-1:0] count_out
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// sequencer: idle, scan over all entries, write-back
	lfu_rt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// entry storage, search trackers and response register
	lfu_rt_dp #(
		.CAPACITY   (CAPACITY),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.opcode    (opcode),
		.key       (key),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.key_out   (key_out),
		.count_out (count_out)
	);

	// a taken request blocks further requests until its write-back
	`LFU_ASSERT_NEXT(a_start_blocks, clk, arst_n, cmd.start, req_stall)
	// write-back never overwrites a response that is still held
	`LFU_ASSERT_SAME(a_commit_free, clk, arst_n, cmd.commit, !rsp_valid || !rsp_stall)
	// a response only appears after a write-back
	`LFU_ASSERT_SAME(a_rsp_from_commit, clk, arst_n, $rose(rsp_valid), $past(cmd.commit))

endmodule

FILE: bench/lfu_replacement_table_test.sv
// ----------------------------------------------------------------------------
// lfu replacement table testbench
// drives access and evict requests through the valid/stall request channel,
// predicts every response with a cycle-free model of the use-count table and
// checks each response field by field, in order, under several idle patterns
// ----------------------------------------------------------------------------
module lfu_replacement_table_test;
	import lfu_rt_pkg::*;

	// one request and one response as they cross the channels
	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] k;
	} lfu_req_t;

	typedef struct packed {
		status_t              st;
		logic [KEY_W-1:0]     k;
		logic [OUT_CNT_W-1:0] cnt;
	} lfu_rsp_t;

	localparam logic [LFU_COUNT_BITS-1:0] COUNT_SAT = '1;
	localparam int                        POOL_SIZE = 24;

	// clock, reset and block ports; the driven ones are known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic                 opcode    = 1'b0;
	logic [KEY_W-1:0]     key       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [KEY_W-1:0]     key_out;
	logic [OUT_CNT_W-1:0] count_out;

	// shadow copy of the table, updated when a request is accepted
	logic                      tbl_valid [LFU_CAPACITY];
	logic [KEY_W-1:0]          tbl_key   [LFU_CAPACITY];
	logic [LFU_COUNT_BITS-1:0] tbl_count [LFU_CAPACITY];
	logic [STAMP_W-1:0]        tbl_stamp [LFU_CAPACITY];
	logic [STAMP_W-1:0]        next_stamp;

	lfu_req_t pending_reqs [$];   // requests not yet offered
	lfu_rsp_t expected_rsps [$];  // predicted responses, oldest first

	int  send_idle_pct = 0;  // chance per cycle that the sender holds back
	int  stall_pct     = 0;  // chance per cycle that the receiver stalls
	logic rsp_hold     = 1'b0;  // long receiver hold-off for back-pressure
	int  rsp_seen      = 0;
	int  mismatches    = 0;

	lfu_replacement_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.opcode    (opcode),
		.key       (key),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.key_out   (key_out),
		.count_out (count_out)
	);

	always #1 clk = ~clk;

	// works out the response of one accepted request and updates the shadow table
	function automatic void predict_lfu(input op_t op, input logic [KEY_W-1:0] k);
		int       hit_at;
		int       free_at;
		int       victim;
		lfu_rsp_t r;
		hit_at  = -1;
		free_at = -1;
		victim  = -1;
		if (op == OP_ACCESS) begin
			for (int i = 0; i < LFU_CAPACITY; i++) begin
				if (tbl_valid[i] && tbl_key[i] == k && hit_at < 0)
					hit_at = i;
				// lowest-numbered free entry takes a new key
				if (!tbl_valid[i] && free_at < 0)
					free_at = i;
			end
			if (hit_at >= 0) begin
				// a saturated count keeps its value and its stamp
				if (tbl_count[hit_at] != COUNT_SAT) begin
					tbl_count[hit_at] = tbl_count[hit_at] + 1'b1;
					tbl_stamp[hit_at] = next_stamp;
					next_stamp        = next_stamp + 1'b1;
				end
				r = '{ST_HIT, k, OUT_CNT_W'(tbl_count[hit_at])};
			end else if (free_at < 0) begin
				// table full: refused, nothing changes
				r = '{ST_FULL, k, '0};
			end else begin
				tbl_valid[free_at] = 1'b1;
				tbl_key[free_at]   = k;
				tbl_count[free_at] = LFU_COUNT_BITS'(1);
				tbl_stamp[free_at] = next_stamp;
				next_stamp         = next_stamp + 1'b1;
				r = '{ST_INSERT, k, OUT_CNT_W'(1)};
			end
		end else begin
			// lowest count wins, ties go to the most recent arrival at that count
			for (int i = 0; i < LFU_CAPACITY; i++) begin
				if (tbl_valid[i] && (victim < 0 || tbl_count[i] < tbl_count[victim] ||
						(tbl_count[i] == tbl_count[victim] &&
						tbl_stamp[i] > tbl_stamp[victim])))
					victim = i;
			end
			if (victim < 0) begin
				r = '{ST_EMPTY, '0, '0};
			end else begin
				tbl_valid[victim] = 1'b0;
				r = '{ST_EVICT, tbl_key[victim], OUT_CNT_W'(tbl_count[victim])};
			end
		end
		expected_rsps.push_back(r);
	endfunction

	// request driver: predicts on acceptance, then offers the next pending request
	always @(posedge clk or negedge arst_n) begin : drive_req
		lfu_req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			opcode    <= OP_ACCESS;
			key       <= '0;
			for (int i = 0; i < LFU_CAPACITY; i++)
				tbl_valid[i] = 1'b0;
			next_stamp = '0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				predict_lfu(op_t'(opcode), key);
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_reqs.pop_front();
				req_valid <= 1'b1;
				opcode    <= nxt.op;
				key       <= nxt.k;
			end else begin
				// idle cycle: payload is noise while valid is low
				req_valid <= 1'b0;
				opcode    <= 1'($urandom_range(1));
				key       <= $urandom;
			end
		end
	end

	// response monitor: checks accepted responses and drives the stall
	always @(posedge clk or negedge arst_n) begin : check_rsp
		lfu_rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsp_seen <= rsp_seen + 1;
				if (expected_rsps.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected response: status %0d key %h count %0d",
							status, key_out, count_out);
					mismatches <= mismatches + 1;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (status !== exp_rsp.st || key_out !== exp_rsp.k ||
							count_out !== exp_rsp.cnt) begin
						if (mismatches < 10)
							$display("response %0d: expected %0d/%h/%0d got %0d/%h/%0d",
								rsp_seen, exp_rsp.st, exp_rsp.k, exp_rsp.cnt,
								status, key_out, count_out);
						mismatches <= mismatches + 1;
					end
				end
			end
			rsp_stall <= rsp_hold || ($urandom_range(99) < stall_pct);
		end
	end

	// back-pressure: once traffic is flowing, stall responses long enough that
	// the block fills up and stalls the request channel
	initial begin : hold_off
		while (rsp_seen < 30)
			@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (400)
			@(posedge clk);
		rsp_hold <= 1'b0;
	end

	initial begin : stimulus
		logic [KEY_W-1:0] key_pool [POOL_SIZE];
		int               evict_pct;
		lfu_req_t         r;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;

		// directed: evict on empty table
		pending_reqs.push_back('{OP_EVICT, 32'h1234_5678});
		// insert the extreme keys, then a hit
		pending_reqs.push_back('{OP_ACCESS, 32'h0000_0000});
		pending_reqs.push_back('{OP_ACCESS, 32'hFFFF_FFFF});
		pending_reqs.push_back('{OP_ACCESS, 32'h0000_0000});
		// fill the remaining fourteen entries
		for (int i = 0; i < LFU_CAPACITY - 2; i++)
			pending_reqs.push_back('{OP_ACCESS, 32'hA5A5_0000 | (32'h1 << i)});
		// full table refuses a new key
		pending_reqs.push_back('{OP_ACCESS, 32'h5555_5555});
		// two keys at count 2, the all-ones key most recent
		pending_reqs.push_back('{OP_ACCESS, 32'hFFFF_FFFF});
		// evict picks the newest of the count-1 keys, then the free slot is reused
		pending_reqs.push_back('{OP_EVICT, 32'h0});
		pending_reqs.push_back('{OP_ACCESS, 32'h5555_5555});
		pending_reqs.push_back('{OP_EVICT, 32'hFFFF_FFFF});

		// drain the table, then evict three more times on the empty table
		repeat (LFU_CAPACITY)
			pending_reqs.push_back('{OP_EVICT, 32'h0});
		pending_reqs.push_back('{OP_EVICT, 32'h0});
		pending_reqs.push_back('{OP_EVICT, 32'h0});

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		// four idle patterns: none, sender, receiver, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 53 : (ph == 3) ? 36 : 0;
			stall_pct     = (ph == 2) ? 53 : (ph == 3) ? 36 : 0;
			// chunks with a varying evict mix so the table swings between empty and full
			for (int c = 0; c < 5; c++) begin
				case ($urandom_range(3))
					0: evict_pct = 5;
					1: evict_pct = 20;
					2: evict_pct = 45;
					default: evict_pct = 70;
				endcase
				for (int n = 0; n < 75; n++) begin
					if ($urandom_range(99) < evict_pct)
						r.op = OP_EVICT;
					else
						r.op = OP_ACCESS;
					// mostly keys from a small pool so hits and a full table occur
					if ($urandom_range(99) < 75)
						r.k = key_pool[$urandom_range(POOL_SIZE - 1)];
					else
						r.k = $urandom;
					pending_reqs.push_back(r);
				end
			end
			while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
				@(posedge clk);
		end

		// quiet period to catch stray responses
		repeat (40)
			@(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("lfu_replacement_table: match");
		else
			$display("lfu_replacement_table: mismatch");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("lfu_replacement_table: mismatch");
		$finish;
	end

endmodule

FILE: lfu_replacement_table.f
+incdir+rtl
rtl/lfu_rt_pkg.sv
rtl/lfu_rt_ram.sv
rtl/lfu_rt_ctrl.sv
rtl/lfu_rt_dp.sv
rtl/lfu_replacement_table.sv
bench/lfu_replacement_table_test.sv
